[rtl/figure_eight_velocity_generator_macros.svh]
// Assertion macros for the figure-eight velocity generator.
`ifndef FIGURE_EIGHT_VELOCITY_GENERATOR_MACROS_SVH
`define FIGURE_EIGHT_VELOCITY_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define FEVG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fevg: same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define FEVG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fevg: next-cycle check failed");
`else
`define FEVG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FEVG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/fevg_pkg.sv]
// Shared types, constants and the cosine table builder for the velocity generator.
package fevg_pkg;

    // Field widths
    localparam int unsigned TABLE_BITS_DEF = 10;
    localparam int unsigned PERIOD_W       = 8;
    localparam int unsigned VEL_W          = 19;
    localparam int unsigned EASE_W         = 17;
    localparam int unsigned GAIN_W         = 18;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned QUEUE_DEPTH    = 2;

    // Shared multiplier geometry
    localparam int unsigned MUL_A_W = 33;
    localparam int unsigned MUL_B_W = 32;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [EASE_W-1:0] EASE_ONE = 17'd65536;

    // Register reset values
    localparam logic [WORD_W-1:0] PHASE_STEP_RST   = 32'd687195;
    localparam logic [GAIN_W-1:0] GAIN_X_RST       = 18'd70372;
    localparam logic [GAIN_W-1:0] GAIN_Z_RST       = 18'd140743;
    localparam logic [WORD_W-1:0] RAMP_INVERSE_RST = 32'd1431656;
    localparam logic [WORD_W-1:0] RUN_LIMIT_RST    = 32'd60000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP   = 3'd0,
        CFG_GAIN_X       = 3'd1,
        CFG_GAIN_Z       = 3'd2,
        CFG_RAMP_INVERSE = 3'd3,
        CFG_RUN_LIMIT    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] phase_step;
        logic [GAIN_W-1:0] gain_x;
        logic [GAIN_W-1:0] gain_z;
        logic [WORD_W-1:0] ramp_inverse;
        logic [WORD_W-1:0] run_limit_ms;
    } t_cfg;

    // One queued job from the front end
    typedef struct packed {
        logic [WORD_W-1:0] phase_acc;
        logic [WORD_W-1:0] elapsed_ms;
        logic              finished;
        logic              skip;
    } t_job;

    // Back-end sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_P,
        S_A,
        S_XA,
        S_XX,
        S_X3,
        S_EB,
        S_EC,
        S_MX,
        S_GX,
        S_MZ,
        S_GZ,
        S_OUT
    } t_seq_state;

    // Taylor series constants, Q30
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TAYLOR_DEN [7] = '{64'sd182, 64'sd132, 64'sd90, 64'sd56,
                                          64'sd30, 64'sd12, 64'sd2};

    // Quarter-wave cosine entry k in Q16, evaluated at elaboration
    function automatic logic [EASE_W-1:0] cos_entry(input int unsigned k,
                                                    input int unsigned tb);
        longint x;
        longint x2;
        longint t;
        x  = (HALF_PI_Q30 * longint'(k)) >>> tb;
        x2 = (x * x) >>> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 7; i++) begin
            t = Q30_ONE - ((x2 * t) / Q30_ONE) / TAYLOR_DEN[i];
        end
        if (t < 0) begin
            t = 0;
        end
        t = (t + 64'sd8192) >>> 14;
        if (t > 64'sd65536) begin
            t = 64'sd65536;
        end
        return t[EASE_W-1:0];
    endfunction

endpackage

[rtl/fevg_ifs.sv]
// Handshake interfaces for the tick, command and configuration channels.
interface fevg_tick_if import fevg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_ms;

    modport source (output valid, output period_ms, input ready);
    modport sink   (input valid, input period_ms, output ready);
endinterface

interface fevg_cmd_if import fevg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_z;
    logic [EASE_W-1:0]        ease;
    logic                     finished;

    modport source (output valid, output vel_x, output vel_z, output ease,
                    output finished, input ready);
    modport sink   (input valid, input vel_x, input vel_z, input ease,
                    input finished, output ready);
endinterface

interface fevg_cfg_if import fevg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/fevg_front.sv]
// Front end: takes ticks, advances time and phase, marks finishing, queues jobs.
module fevg_front import fevg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fevg_tick_if.sink i_tick,
    input  t_cfg      i_cfg,
    output logic      o_push_valid,
    input  logic      i_push_ready,
    output t_job      o_push_job
);

    logic [WORD_W-1:0] r_elapsed, n_elapsed;
    logic [WORD_W-1:0] r_phase, n_phase;
    logic              r_done, n_done;
    logic [WORD_W:0]   w_sum;
    logic [WORD_W-1:0] w_elapsed;
    logic [WORD_W-1:0] w_phase;
    logic              w_fin;
    logic              w_accept;

    assign i_tick.ready = i_push_ready;
    assign o_push_valid = i_tick.valid;
    assign w_accept     = i_tick.valid && i_push_ready;

    // Saturating clock, wrapping phase, finish compare
    always_comb begin
        w_sum     = {1'b0, r_elapsed} + (WORD_W+1)'(i_tick.period_ms);
        w_elapsed = w_sum[WORD_W] ? '1 : w_sum[WORD_W-1:0];
        w_phase   = r_phase + i_cfg.phase_step * WORD_W'(i_tick.period_ms);
        w_fin     = (w_elapsed >= i_cfg.run_limit_ms);
    end

    // Job built for the queue; once finished, jobs carry only the skip mark
    always_comb begin
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        n_done    = r_done;
        if (r_done) begin
            o_push_job.phase_acc  = r_phase;
            o_push_job.elapsed_ms = r_elapsed;
            o_push_job.finished   = 1'b1;
            o_push_job.skip       = 1'b1;
        end else begin
            o_push_job.phase_acc  = w_phase;
            o_push_job.elapsed_ms = w_elapsed;
            o_push_job.finished   = w_fin;
            o_push_job.skip       = 1'b0;
            if (w_accept) begin
                n_elapsed = w_elapsed;
                n_phase   = w_phase;
                n_done    = w_fin;
            end
        end
    end

    // Trajectory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_phase   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_done    <= n_done;
        end
    end

endmodule

[rtl/fevg_queue.sv]
// Short job queue between the front and back ends.
module fevg_queue import fevg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/fevg_back.sv]
// Back end: ease polynomial, cosine lookups and velocity scaling on one multiplier.
module fevg_back import fevg_pkg::*; #(
    parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_job        i_pop_job,
    fevg_cmd_if.source  o_cmd
);

    localparam int unsigned TAB_N  = 1 << TABLE_BITS;
    localparam int unsigned ADDR_W = TABLE_BITS + 1;
    localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(TAB_N);
    localparam logic [19:0] A_OFFSET = 20'd983040;
    localparam logic [19:0] B_OFFSET = 20'd655360;

    t_seq_state r_state, n_state;

    logic [WORD_W-1:0]  r_phase;
    logic [WORD_W-1:0]  r_elapsed;
    logic               r_fin;
    logic               r_skip;
    logic [PROD_W-1:0]  r_prod;
    logic [15:0]        r_x;
    logic               r_sat;
    logic               r_aneg;
    logic [19:0]        r_amag;
    logic [19:0]        r_b;
    logic [EASE_W-1:0]  r_rom;
    logic [EASE_W-1:0]  r_cx;
    logic [EASE_W-1:0]  r_cz;
    logic [EASE_W-1:0]  r_ease;
    logic signed [VEL_W-1:0] r_vx;
    logic               r_out_valid;
    logic signed [VEL_W-1:0] r_out_vx;
    logic signed [VEL_W-1:0] r_out_vz;
    logic [EASE_W-1:0]  r_out_ease;
    logic               r_out_fin;

    logic               w_mul_en;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic               w_load_out;
    logic               w_pop;
    logic [EASE_W-1:0]  w_tab [TAB_N+1];
    logic [ADDR_W-1:0]  w_rom_addr;
    logic [ADDR_W-1:0]  w_addr_x;
    logic [ADDR_W-1:0]  w_addr_z;
    logic [1:0]         w_quad_x;
    logic [1:0]         w_quad_z;
    logic [WORD_W-1:0]  w_phase2;
    logic               w_neg_x;
    logic               w_neg_z;
    logic [18:0]        w_six_x;
    logic               w_aneg;
    logic [19:0]        w_amag;
    logic [19:0]        w_q;
    logic [19:0]        w_b;
    logic [20:0]        w_e3;
    logic [EASE_W-1:0]  w_ease;
    logic signed [VEL_W-1:0] w_vel_x;
    logic signed [VEL_W-1:0] w_vel_z;

    // Rounded, signed velocity from gain*|c|*ease
    function automatic logic signed [VEL_W-1:0] vel_round(input logic [PROD_W-1:0] prod,
                                                          input logic neg);
        logic [50:0]      sum;
        logic [VEL_W-1:0] mag;
        sum = prod[50:0] + (51'd1 << 31);
        mag = sum[50:32];
        return neg ? signed'(-mag) : signed'(mag);
    endfunction

    // Quarter-wave cosine ROM, built at elaboration
    for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
        assign w_tab[k] = cos_entry(k, TABLE_BITS);
    end

    // Quadrant folding for cos(phase) and cos(2*phase)
    always_comb begin
        w_phase2 = {r_phase[WORD_W-2:0], 1'b0};
        w_quad_x = r_phase[31:30];
        w_quad_z = w_phase2[31:30];
        w_neg_x  = w_quad_x[1] ^ w_quad_x[0];
        w_neg_z  = w_quad_z[1] ^ w_quad_z[0];
        w_addr_x = w_quad_x[0] ? ADDR_TOP - ADDR_W'(r_phase[29 -: TABLE_BITS])
                               : ADDR_W'(r_phase[29 -: TABLE_BITS]);
        w_addr_z = w_quad_z[0] ? ADDR_TOP - ADDR_W'(w_phase2[29 -: TABLE_BITS])
                               : ADDR_W'(w_phase2[29 -: TABLE_BITS]);
        w_rom_addr = (r_state == S_XA) ? w_addr_x : w_addr_z;
    end

    // Ease polynomial helpers: a = 6x - 15, b = x*a + 10, final clamp
    always_comb begin
        w_six_x = 19'({r_prod[31:16], 2'b00}) + 19'({r_prod[31:16], 1'b0});
        w_aneg  = (20'(w_six_x) < A_OFFSET);
        w_amag  = w_aneg ? A_OFFSET - 20'(w_six_x) : 20'(w_six_x) - A_OFFSET;
        w_q     = r_prod[35:16];
        w_b     = r_aneg ? B_OFFSET - w_q : B_OFFSET + w_q;
        w_e3    = r_prod[36:16];
        if (r_sat || (w_e3 > 21'(EASE_ONE))) begin
            w_ease = EASE_ONE;
        end else begin
            w_ease = w_e3[EASE_W-1:0];
        end
        w_vel_x = vel_round(r_prod, w_neg_x);
        w_vel_z = vel_round(r_prod, w_neg_z);
    end

    assign o_pop_ready = (r_state == S_IDLE);
    assign w_pop       = i_pop_valid && o_pop_ready;

    // Sequencer: next state and multiplier operands
    always_comb begin
        n_state    = r_state;
        w_mul_en   = 1'b0;
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_state = i_pop_job.skip ? S_OUT : S_P;
                end
            end
            S_P: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_elapsed);
                w_mul_b  = i_cfg.ramp_inverse;
                n_state  = S_A;
            end
            S_A: begin
                n_state = S_XA;
            end
            S_XA: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_x);
                w_mul_b  = MUL_B_W'(r_amag);
                n_state  = S_XX;
            end
            S_XX: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_x);
                w_mul_b  = MUL_B_W'(r_x);
                n_state  = S_X3;
            end
            S_X3: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_prod[31:16]);
                w_mul_b  = MUL_B_W'(r_x);
                n_state  = S_EB;
            end
            S_EB: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_prod[31:16]);
                w_mul_b  = MUL_B_W'(r_b);
                n_state  = S_EC;
            end
            S_EC: begin
                n_state = S_MX;
            end
            S_MX: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_cx);
                w_mul_b  = MUL_B_W'(r_ease);
                n_state  = S_GX;
            end
            S_GX: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_prod[MUL_A_W-1:0];
                w_mul_b  = MUL_B_W'(i_cfg.gain_x);
                n_state  = S_MZ;
            end
            S_MZ: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_cz);
                w_mul_b  = MUL_B_W'(r_ease);
                n_state  = S_GZ;
            end
            S_GZ: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_prod[MUL_A_W-1:0];
                w_mul_b  = MUL_B_W'(i_cfg.gain_z);
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_cmd.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared multiplier and ROM read port
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
        r_rom <= w_tab[w_rom_addr];
    end

    // Datapath captures per step
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_phase   <= i_pop_job.phase_acc;
            r_elapsed <= i_pop_job.elapsed_ms;
            r_fin     <= i_pop_job.finished;
            r_skip    <= i_pop_job.skip;
        end
        unique case (r_state)
            S_A: begin
                r_x    <= r_prod[31:16];
                r_sat  <= |r_prod[PROD_W-1:32];
                r_aneg <= w_aneg;
                r_amag <= w_amag;
            end
            S_XX: begin
                r_b  <= w_b;
                r_cx <= r_rom;
            end
            S_X3: begin
                r_cz <= r_rom;
            end
            S_EC: begin
                r_ease <= w_ease;
            end
            S_MZ: begin
                r_vx <= w_vel_x;
            end
            default: begin
            end
        endcase
    end

    // Output register, one command deep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (r_skip) begin
                r_out_vx   <= '0;
                r_out_vz   <= '0;
                r_out_ease <= '0;
                r_out_fin  <= 1'b1;
            end else begin
                r_out_vx   <= r_vx;
                r_out_vz   <= w_vel_z;
                r_out_ease <= r_ease;
                r_out_fin  <= r_fin;
            end
        end
    end

    assign o_cmd.valid    = r_out_valid;
    assign o_cmd.vel_x    = r_out_vx;
    assign o_cmd.vel_z    = r_out_vz;
    assign o_cmd.ease     = r_out_ease;
    assign o_cmd.finished = r_out_fin;

endmodule

[rtl/figure_eight_velocity_generator.sv]
// Figure-eight velocity generator: one velocity command per tick after a two-entry job queue.
// A tick passes through the job queue, the back-end sequencer and the output register to its command.
// The back end takes a job only while idle, stepping it through the single shared 33x32 multiplier;
// finished jobs skip to the output. The front end takes a tick a cycle while the queue has room.
// Reset (synchronous, active low): clock, phase and finished flag cleared, registers to defaults,
// queue and output emptied; the cosine ROM is constant and needs no clearing pass.
`include "figure_eight_velocity_generator_macros.svh"

module figure_eight_velocity_generator import fevg_pkg::*; #(
    parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fevg_tick_if.sink  i_tick,
    fevg_cmd_if.source o_cmd,
    fevg_cfg_if.sink   i_cfg
);

    t_cfg r_cfg;
    logic w_push_valid;
    logic w_push_ready;
    t_job w_push_job;
    logic w_pop_valid;
    logic w_pop_ready;
    t_job w_pop_job;

    // Configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= PHASE_STEP_RST;
            r_cfg.gain_x       <= GAIN_X_RST;
            r_cfg.gain_z       <= GAIN_Z_RST;
            r_cfg.ramp_inverse <= RAMP_INVERSE_RST;
            r_cfg.run_limit_ms <= RUN_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg.data;
                CFG_GAIN_X:       r_cfg.gain_x       <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_Z:       r_cfg.gain_z       <= i_cfg.data[GAIN_W-1:0];
                CFG_RAMP_INVERSE: r_cfg.ramp_inverse <= i_cfg.data;
                CFG_RUN_LIMIT:    r_cfg.run_limit_ms <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    fevg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (i_tick),
        .i_cfg        (r_cfg),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    fevg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    fevg_back #(
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_job   (w_pop_job),
        .o_cmd       (o_cmd)
    );

    // A queued tick is visible to the back end on the following cycle
    `FEVG_ASSERT_NXT(a_tick_reaches_queue, i_clk, i_rst_n,
                     i_tick.valid && i_tick.ready, w_pop_valid)
    // Zero ease must give zero velocities
    `FEVG_ASSERT_IMP(a_zero_ease_zero_vel, i_clk, i_rst_n,
                     o_cmd.valid && (o_cmd.ease == '0),
                     (o_cmd.vel_x == '0) && (o_cmd.vel_z == '0))
    // Ease never exceeds one
    `FEVG_ASSERT_IMP(a_ease_capped, i_clk, i_rst_n, o_cmd.valid, o_cmd.ease <= EASE_ONE)

endmodule

[test/tb.sv]
// Self-checking testbench for the figure-eight velocity generator, with its own trajectory predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fevg_pkg::*;

    localparam int     TAB_BITS         = TABLE_BITS_DEF;
    localparam int     TAB_N            = 1 << TAB_BITS;
    localparam longint Q16              = 64'sd65536;
    localparam longint Q30              = 64'sd1 << 30;
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;   // pi/2 in Q30
    localparam logic [WORD_W-1:0] WORD_MAX = '1;
    localparam int     RANDOM_TICKS     = 1410;
    localparam int     MAX_GAP          = 19;
    localparam int     HOLD_CYCLES      = 300;
    localparam int     DRAIN_CYCLES     = 32;

    // One expected velocity command
    typedef struct packed {
        logic [VEL_W-1:0]  vel_x;
        logic [VEL_W-1:0]  vel_z;
        logic [EASE_W-1:0] ease;
        logic              finished;
    } t_command;

    logic clk;
    logic rst_n;

    fevg_tick_if tick_ch ();
    fevg_cmd_if  cmd_ch ();
    fevg_cfg_if  cfg_ch ();

    figure_eight_velocity_generator DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_ch),
        .o_cmd   (cmd_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor: register copies and trajectory state
    logic [WORD_W-1:0] cfg_phase_step   = 32'd687195;
    logic [GAIN_W-1:0] cfg_gain_x       = 18'd70372;
    logic [GAIN_W-1:0] cfg_gain_z       = 18'd140743;
    logic [WORD_W-1:0] cfg_ramp_inverse = 32'd1431656;
    logic [WORD_W-1:0] cfg_run_limit    = 32'd60000;
    logic [WORD_W-1:0] st_elapsed       = '0;
    logic [WORD_W-1:0] st_phase         = '0;
    bit                st_done          = 1'b0;
    int                cos_q16 [TAB_N+1];

    t_command due_commands [$];
    int       fault_count = 0;
    int       cmd_count   = 0;
    int       hold_left   = 0;
    bit       src_calm    = 1'b0;
    bit       snk_calm    = 1'b0;

    // Quarter-wave cosine entry in Q16 from a degree-14 Taylor series in Q30
    function automatic int cos_point(input int k);
        longint ang;
        longint ang2;
        longint acc;
        ang  = (QUARTER_TURN_Q30 * k) / TAB_N;
        ang2 = (ang * ang) / Q30;
        acc  = Q30;
        // Horner form, divisors (2n)(2n-1) from n = 7 down to 1
        for (int i = 0; i < 7; i++) begin
            acc = Q30 - ((ang2 * acc) / Q30) / ((14 - 2 * i) * (13 - 2 * i));
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 64'sd8192) >>> 14;
        if (acc > Q16) begin
            acc = Q16;
        end
        return int'(acc);
    endfunction

    // Signed cosine of a 32-bit phase via quadrant folding
    function automatic int cos_lookup(input logic [WORD_W-1:0] ph);
        int idx;
        int mag;
        idx = int'(ph[WORD_W-3 -: TAB_BITS]);
        mag = ph[WORD_W-2] ? cos_q16[TAB_N - idx] : cos_q16[idx];
        return (ph[WORD_W-1] ^ ph[WORD_W-2]) ? -mag : mag;
    endfunction

    // Quintic smoothstep of the ramp position, Q16
    function automatic int ease_now();
        logic [63:0] prod;
        longint x;
        longint a;
        longint b;
        longint e;
        prod = 64'(st_elapsed) * 64'(cfg_ramp_inverse);
        if (prod >= 64'h1_0000_0000) begin
            return int'(Q16);
        end
        x = longint'(prod >> 16);
        a = 6 * x - 15 * Q16;
        b = (x * a) / Q16 + 10 * Q16;
        e = (x * x) >>> 16;
        e = (e * x) >>> 16;
        e = (e * b) >>> 16;
        if (e < 0) begin
            e = 0;
        end
        if (e > Q16) begin
            e = Q16;
        end
        return int'(e);
    endfunction

    // gain * cos * ease, rounded, sign restored, wrapped to the output width
    function automatic logic [VEL_W-1:0] scale_velocity(input logic [GAIN_W-1:0] gain,
                                                         input int c, input int ez);
        logic [63:0] mag;
        logic [63:0] v;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        v   = (64'(gain) * mag * 64'(ez) + 64'h8000_0000) >> 32;
        if (c < 0) begin
            v = -v;
        end
        return v[VEL_W-1:0];
    endfunction

    // Advance the trajectory by one tick and return the command it should produce
    function automatic t_command advance_trajectory(input logic [PERIOD_W-1:0] period);
        t_command          r;
        logic [WORD_W:0]   sum;
        int                ez;
        r = '0;
        if (st_done) begin
            r.finished = 1'b1;
            return r;
        end
        sum        = {1'b0, st_elapsed} + (WORD_W+1)'(period);
        st_elapsed = sum[WORD_W] ? WORD_MAX : sum[WORD_W-1:0];
        st_phase   = st_phase + cfg_phase_step * WORD_W'(period);
        ez         = ease_now();
        r.vel_x    = scale_velocity(cfg_gain_x, cos_lookup(st_phase), ez);
        r.vel_z    = scale_velocity(cfg_gain_z, cos_lookup({st_phase[WORD_W-2:0], 1'b0}), ez);
        r.ease     = ez[EASE_W-1:0];
        r.finished = (st_elapsed >= cfg_run_limit);
        if (r.finished) begin
            st_done = 1'b1;
        end
        return r;
    endfunction

    // Register copy update; unknown indexes are dropped
    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [WORD_W-1:0] val);
        case (idx)
            CFG_PHASE_STEP:   cfg_phase_step   = val;
            CFG_GAIN_X:       cfg_gain_x       = val[GAIN_W-1:0];
            CFG_GAIN_Z:       cfg_gain_z       = val[GAIN_W-1:0];
            CFG_RAMP_INVERSE: cfg_ramp_inverse = val;
            CFG_RUN_LIMIT:    cfg_run_limit    = val;
            default:          ;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_gain_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return WORD_MAX;          // masked to full scale
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fault_count++;
        $display("%0t ns: command %0d %s: got %0d, expected %0d",
                 $time, cmd_count, what, got, want);
    endtask

    // One tick transaction, with a random lead-in gap
    task automatic send_tick(input logic [PERIOD_W-1:0] period);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.period_ms <= period;
        do @(posedge clk); while (!tick_ch.ready);
        due_commands.push_back(advance_trajectory(period));
    endtask

    // One configuration transaction; only called with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        store_register(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering ticks and wait for every outstanding command
    task automatic drain_commands();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (due_commands.size() != 0) @(posedge clk);
    endtask

    // Reset defaults, zero periods, first steps of the ramp
    task automatic test_reset_defaults();
        send_tick(8'd0);
        send_tick(8'd1);
        send_tick(8'hFF);
        send_tick(8'h80);
        send_tick(8'd0);
    endtask

    // Quarter-turn steps land on every quadrant boundary, full gains and ease
    task automatic test_quadrant_walk();
        drain_commands();
        write_register(CFG_PHASE_STEP, 32'h4000_0000);
        write_register(CFG_GAIN_X, 32'h0003_FFFF);
        write_register(CFG_GAIN_Z, WORD_MAX);
        write_register(CFG_RAMP_INVERSE, WORD_MAX);
        repeat (8) send_tick(8'd1);
        drain_commands();
        write_register(CFG_PHASE_STEP, WORD_MAX);
        send_tick(8'hFF);
        send_tick(8'd3);
    endtask

    // Zero ramp holds the ease at zero; zero gains null the velocities
    task automatic test_zero_scaling();
        drain_commands();
        write_register(CFG_RAMP_INVERSE, '0);
        send_tick(8'd7);
        drain_commands();
        write_register(CFG_RAMP_INVERSE, WORD_MAX);
        write_register(CFG_GAIN_X, '0);
        write_register(CFG_GAIN_Z, '0);
        send_tick(8'd200);
    endtask

    // Writes to indexes past the register list must change nothing
    task automatic test_spare_registers();
        drain_commands();
        write_register(CFG_GAIN_X, $urandom);
        write_register(CFG_GAIN_Z, $urandom);
        for (int r = CFG_RUN_LIMIT + 1; r <= {CFG_IDX_W{1'b1}}; r++) begin
            write_register(r[CFG_IDX_W-1:0], $urandom);
        end
        send_tick(PERIOD_W'($urandom_range(0, 255)));
    endtask

    // Phases of random ticks under random settings, kept short of the run limit
    task automatic test_random_trajectory();
        int unsigned sent;
        int unsigned len;
        int unsigned span;
        bit          short_ticks;
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            len  = $urandom_range(30, 120);
            drain_commands();
            span = st_elapsed + 255 * len + 1;
            src_calm    = ($urandom_range(0, 3) == 0);
            snk_calm    = ($urandom_range(0, 3) == 0);
            short_ticks = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       write_register(CFG_PHASE_STEP, '0);
                    1:       write_register(CFG_PHASE_STEP, WORD_MAX);
                    2:       write_register(CFG_PHASE_STEP, 32'd1 << $urandom_range(0, 31));
                    default: write_register(CFG_PHASE_STEP, $urandom);
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                write_register(CFG_GAIN_X, random_gain_word());
            end
            if ($urandom_range(0, 3) != 0) begin
                write_register(CFG_GAIN_Z, random_gain_word());
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       write_register(CFG_RAMP_INVERSE, '0);
                    1:       write_register(CFG_RAMP_INVERSE, WORD_MAX);
                    // keep the product inside the ramp for the whole phase
                    2, 3:    write_register(CFG_RAMP_INVERSE,
                                            $urandom_range(1, WORD_MAX / span));
                    default: write_register(CFG_RAMP_INVERSE, $urandom);
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                write_register(CFG_RUN_LIMIT, WORD_MAX);
            end else begin
                write_register(CFG_RUN_LIMIT, $urandom_range(span, WORD_MAX));
            end
            repeat (len) begin
                send_tick(short_ticks ? PERIOD_W'($urandom_range(0, 3))
                                      : PERIOD_W'($urandom_range(0, 255)));
            end
            sent += len;
        end
        src_calm = 1'b0;
        snk_calm = 1'b0;
    endtask

    // Long hold on the command side while ticks keep coming back to back
    task automatic test_output_stall();
        drain_commands();
        src_calm = 1'b1;
        @(negedge clk);
        hold_left = HOLD_CYCLES;
        repeat (12) send_tick(PERIOD_W'($urandom_range(0, 255)));
        src_calm = 1'b0;
    endtask

    // Reach the run limit, then keep ticking in the finished state
    task automatic test_run_limit();
        drain_commands();
        write_register(CFG_RAMP_INVERSE, WORD_MAX);
        write_register(CFG_GAIN_X, random_gain_word());
        if ($urandom_range(0, 3) == 0) begin
            write_register(CFG_RUN_LIMIT, '0);
        end else begin
            write_register(CFG_RUN_LIMIT, st_elapsed + $urandom_range(0, 3000));
        end
        while (!st_done) begin
            send_tick(PERIOD_W'($urandom_range(0, 255)));
        end
        repeat (40) send_tick(PERIOD_W'($urandom_range(0, 255)));
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count down the long command-side hold
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
            end
        end
    end

    // Command sink: random stalls, field-by-field check of each transaction
    initial begin : command_sink
        int       stall;
        t_command want;
        stall        = 0;
        cmd_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            cmd_ch.ready <= (hold_left == 0 && stall == 0);
            @(posedge clk);
            if (cmd_ch.valid && cmd_ch.ready) begin
                if (due_commands.size() == 0) begin
                    report_mismatch("command with none outstanding", cmd_ch.vel_x, 0);
                end else begin
                    want = due_commands.pop_front();
                    if (cmd_ch.vel_x !== want.vel_x) begin
                        report_mismatch("vel_x", cmd_ch.vel_x, $signed(want.vel_x));
                    end
                    if (cmd_ch.vel_z !== want.vel_z) begin
                        report_mismatch("vel_z", cmd_ch.vel_z, $signed(want.vel_z));
                    end
                    if (cmd_ch.ease !== want.ease) begin
                        report_mismatch("ease", cmd_ch.ease, want.ease);
                    end
                    if (cmd_ch.finished !== want.finished) begin
                        report_mismatch("finished", cmd_ch.finished, want.finished);
                    end
                end
                cmd_count++;
                stall = snk_calm ? 0 : $urandom_range(0, MAX_GAP);
            end else if (!cmd_ch.ready && stall > 0) begin
                stall--;
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Test sequence
    initial begin : stimulus
        for (int k = 0; k <= TAB_N; k++) begin
            cos_q16[k] = cos_point(k);
        end
        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.period_ms = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_quadrant_walk();
        test_zero_scaling();
        test_spare_registers();
        test_random_trajectory();
        test_output_stall();
        test_run_limit();

        drain_commands();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
